// File: rtl/core/assert_macros.svh
// Assertion macros for the smoother RTL, included by the result queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define PBS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/pbs_pkg.sv
// Types, codes and tangent arithmetic for the polyline Bezier smoother.
`timescale 1ns / 1ps

package pbs_pkg;

	localparam int COORD_W = 16;
	localparam int CTRL_W  = COORD_W + 1;
	localparam int IN_W    = ((2 * COORD_W) + 7) / 8 * 8;
	localparam int RES_W   = 4 * CTRL_W + 2 * COORD_W;
	localparam int OUT_W   = (RES_W + 7) / 8 * 8;
	localparam int USER_W  = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [CTRL_W-1:0]  ctrl_t;
	typedef logic signed [COORD_W:0]   diff_t;
	typedef logic signed [COORD_W+1:0] wide_t;
	typedef logic [1:0]                kind_t;
	typedef logic [1:0]                seen_t;

	localparam kind_t KIND_MOVE  = 2'd0;
	localparam kind_t KIND_QUAD  = 2'd1;
	localparam kind_t KIND_CUBIC = 2'd2;

	localparam seen_t SEEN_NONE = 2'd0;
	localparam seen_t SEEN_ONE  = 2'd1;
	localparam seen_t SEEN_TWO  = 2'd2;
	localparam seen_t SEEN_MORE = 2'd3;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		ctrl_t x;
		ctrl_t y;
	} ctrl_pt_t;

	typedef struct packed {
		logic     path_done;
		logic     run_last;
		kind_t    kind;
		ctrl_pt_t c1;
		ctrl_pt_t c2;
		point_t   end_pt;
	} result_t;

	// (a - b) / 4, truncated toward zero
	function automatic diff_t quarter_diff(coord_t a, coord_t b);
		diff_t d;
		diff_t biased;
		d      = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		biased = d[COORD_W] ? d + diff_t'(3) : d;
		return biased >>> 2;
	endfunction

	// base + (a - b) / 4
	function automatic ctrl_t tan_fwd(coord_t base, coord_t a, coord_t b);
		diff_t q;
		wide_t r;
		q = quarter_diff(a, b);
		r = {{2{base[COORD_W-1]}}, base} + {q[COORD_W], q};
		return r[CTRL_W-1:0];
	endfunction

	// base - (a - b) / 4
	function automatic ctrl_t tan_bwd(coord_t base, coord_t a, coord_t b);
		diff_t q;
		wide_t r;
		q = quarter_diff(a, b);
		r = {{2{base[COORD_W-1]}}, base} - {q[COORD_W], q};
		return r[CTRL_W-1:0];
	endfunction

endpackage

// File: rtl/core/pbs_seg_calc.sv
// Segment kind and control point logic for one incoming point.
`timescale 1ns / 1ps

module pbs_seg_calc (
	input  pbs_pkg::seen_t   seen,
	input  pbs_pkg::point_t  w0,
	input  pbs_pkg::point_t  w1,
	input  pbs_pkg::point_t  w2,
	input  pbs_pkg::point_t  pt,
	input  logic             last,
	output logic [1:0]       res_n,
	output pbs_pkg::result_t res0,
	output pbs_pkg::result_t res1
);
	import pbs_pkg::*;

	point_t prev;

	// missing neighbor before the first segment is the segment start itself
	assign prev = (seen == SEEN_TWO) ? w1 : w0;

	always_comb begin
		res0 = '0;
		res1 = '0;
		res_n = 2'd0;
		unique case (seen)
			SEEN_NONE: begin
				res_n = 2'd1;
				res0.kind = KIND_MOVE;
				res0.end_pt = pt;
				res0.run_last = 1'b1;
				res0.path_done = last;
			end
			SEEN_ONE: begin
				res_n = last ? 2'd1 : 2'd0;
				res0.kind = KIND_QUAD;
				res0.c1.x = tan_bwd(pt.x, pt.x, w2.x);
				res0.c1.y = tan_bwd(pt.y, pt.y, w2.y);
				res0.end_pt = pt;
				res0.run_last = 1'b1;
				res0.path_done = 1'b1;
			end
			SEEN_TWO, SEEN_MORE: begin
				res_n = last ? 2'd2 : 2'd1;
				res0.kind = KIND_CUBIC;
				res0.c1.x = tan_fwd(w1.x, w2.x, prev.x);
				res0.c1.y = tan_fwd(w1.y, w2.y, prev.y);
				res0.c2.x = tan_bwd(w2.x, pt.x, w1.x);
				res0.c2.y = tan_bwd(w2.y, pt.y, w1.y);
				res0.end_pt = w2;
				res0.run_last = !last;
				res0.path_done = 1'b0;
				// closing segment, its successor replaced by its own end
				res1.kind = KIND_CUBIC;
				res1.c1.x = tan_fwd(w2.x, pt.x, w1.x);
				res1.c1.y = tan_fwd(w2.y, pt.y, w1.y);
				res1.c2.x = tan_bwd(pt.x, pt.x, w2.x);
				res1.c2.y = tan_bwd(pt.y, pt.y, w2.y);
				res1.end_pt = pt;
				res1.run_last = 1'b1;
				res1.path_done = 1'b1;
			end
			default: res_n = 2'd0;
		endcase
	end

endmodule

// File: rtl/core/pbs_out_queue.sv
// Four-entry result queue taking up to two results per cycle.
`timescale 1ns / 1ps

module pbs_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  pbs_pkg::result_t wr0,
	input  pbs_pkg::result_t wr1,
	output logic             room,
	output logic             head_valid,
	input  logic             head_ready,
	output pbs_pkg::result_t head
);
	import pbs_pkg::*;

	`include "assert_macros.svh"

	localparam int DEPTH = 4;

	result_t    mem_q [DEPTH];
	logic [1:0] head_q;
	logic [1:0] tail_q;
	logic [2:0] count_q;
	logic       pop;

	assign pop        = head_valid && head_ready;
	assign head_valid = (count_q != 3'd0);
	assign head       = mem_q[head_q];
	// keep space for a two-result request
	assign room       = (count_q <= 3'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[tail_q] <= wr0;
		end
		if (push_n == 2'd2) begin
			mem_q[tail_q + 2'd1] <= wr1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + push_n;
			head_q  <= head_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push_n} - {2'b0, pop};
		end
	end

	`PBS_NEVER(a_count_bound, count_q > 3'(DEPTH), "result queue count out of range")
	`PBS_NEVER(a_push_no_room, (push_n != 2'd0) && (count_q > 3'(DEPTH - 2)), "push without room")
	`PBS_ASSERT(a_pair_closes, (push_n == 2'd2) |-> (wr1.path_done && !wr0.run_last), "result pair must close the path")
	`PBS_NEVER(a_bad_push, push_n == 2'd3, "push count above two")

endmodule

// File: rtl/core/polyline_bezier_smoother_core.sv
// Polyline to Bezier path segment smoother, top level.
//   channel  | dir | tdata                          | tuser            | tlast
//   s_*      | in  | point_x, point_y               | -                | last_point
//   m_*      | out | ctrl1_x/y, ctrl2_x/y, end_x/y  | kind, path_done  | run_last
// One point is taken per cycle while s_tready is high; any results it yields
// are registered into the output queue, which drives m_tvalid from its count.
// A final point of a path of three or more points yields two results; the
// four-entry queue keeps s_tready high at full rate while the sink keeps up.
// s_tready drops when fewer than two queue entries are free.
// Reset clears the point window and the queue; nothing else needs clearing.
`timescale 1ns / 1ps

module polyline_bezier_smoother_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [pbs_pkg::IN_W-1:0]     s_tdata,  // point_x, point_y
	input  logic                         s_tlast,  // last_point
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [pbs_pkg::OUT_W-1:0]    m_tdata,  // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
	output logic [pbs_pkg::USER_W-1:0]   m_tuser,  // segment_kind[1:0], path_done
	output logic                         m_tlast   // run_last
);
	import pbs_pkg::*;

	seen_t      seen_q;
	point_t     win_q [3];
	point_t     pt;
	logic       accept;
	logic [1:0] res_n;
	logic [1:0] push_n;
	result_t    res0;
	result_t    res1;
	result_t    head;

	assign pt.x   = s_tdata[COORD_W-1:0];
	assign pt.y   = s_tdata[2*COORD_W-1:COORD_W];
	assign accept = s_tvalid && s_tready;
	assign push_n = accept ? res_n : 2'd0;

	pbs_seg_calc u_calc (
		.seen  (seen_q),
		.w0    (win_q[0]),
		.w1    (win_q[1]),
		.w2    (win_q[2]),
		.pt    (pt),
		.last  (s_tlast),
		.res_n (res_n),
		.res0  (res0),
		.res1  (res1)
	);

	pbs_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.wr0        (res0),
		.wr1        (res1),
		.room       (s_tready),
		.head_valid (m_tvalid),
		.head_ready (m_tready),
		.head       (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= SEEN_NONE;
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				// path closed: start over with a move
				seen_q <= SEEN_NONE;
				win_q[0] <= '0;
				win_q[1] <= '0;
				win_q[2] <= '0;
			end else begin
				seen_q <= (seen_q == SEEN_MORE) ? SEEN_MORE : seen_q + 2'd1;
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= pt;
			end
		end
	end

	assign m_tdata = OUT_W'({head.end_pt.y, head.end_pt.x, head.c2.y, head.c2.x,
		head.c1.y, head.c1.x});
	assign m_tuser = {head.path_done, head.kind};
	assign m_tlast = head.run_last;

endmodule
